>>> hw/rtl/gbwa_pkg.sv
// Shared types and constants for the bounded gap width average block.
`default_nettype none

package gbwa_pkg;

    localparam int unsigned COLOR_W = 8;
    localparam int unsigned RUN_W   = 12;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned SUM_W   = 23;
    localparam int unsigned AVG_W   = 12;
    localparam int unsigned CFG_AW  = 3;

    localparam logic [RUN_W-1:0]   RUN_MAX   = 12'd4095;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd4194303;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 23'd8388607;
    localparam logic [AVG_W-1:0]   AVG_MAX   = 12'd4095;

    // circular hue wrap
    localparam logic signed [9:0] HUE_WRAP = 10'sd180;

    localparam logic [COLOR_W-1:0] RST_BLACK_VALUE_LIMIT      = 8'd95;
    localparam logic [COLOR_W-1:0] RST_WHITE_SATURATION_LIMIT = 8'd20;
    localparam logic [COLOR_W-1:0] RST_WHITE_VALUE_FLOOR      = 8'd240;
    localparam logic [COLOR_W-1:0] RST_HUE_TOLERANCE          = 8'd40;

    typedef enum logic [CFG_AW-1:0] {
        CFG_LINE_HUE               = 3'd0,
        CFG_LINE_SATURATION        = 3'd1,
        CFG_LINE_VALUE             = 3'd2,
        CFG_BLACK_VALUE_LIMIT      = 3'd3,
        CFG_WHITE_SATURATION_LIMIT = 3'd4,
        CFG_WHITE_VALUE_FLOOR      = 3'd5,
        CFG_HUE_TOLERANCE          = 3'd6
    } t_cfg_reg;

    // classified pixel passed from front to back
    typedef struct packed {
        logic wall;
        logic row_end;
        logic frame_end;
    } t_item;

    typedef struct packed {
        logic [AVG_W-1:0]   average_gap;
        logic [COUNT_W-1:0] gap_count;
        logic [SUM_W-1:0]   gap_length_sum;
        logic               no_gaps;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/gbwa_classify.sv
// Front end: configuration registers and per-pixel wall classification.
`default_nettype none

module gbwa_classify (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [gbwa_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_cfg_wdata,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_pixel_hue,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_pixel_saturation,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_pixel_value,
    input  wire                         i_is_dark,
    input  wire                         i_row_end,
    input  wire                         i_frame_end,
    output gbwa_pkg::t_item             o_item
);
    import gbwa_pkg::*;

    logic [COLOR_W-1:0] r_line_hue, r_line_sat, r_line_val;
    logic [COLOR_W-1:0] r_black_lim, r_white_sat_lim, r_white_val_floor, r_hue_tol;

    logic              pix_white, line_white, pix_black, line_black;
    logic signed [9:0] hue_diff, hue_abs, hue_alt, hue_dist;
    logic              hue_match, color_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_hue        <= '0;
            r_line_sat        <= '0;
            r_line_val        <= '0;
            r_black_lim       <= RST_BLACK_VALUE_LIMIT;
            r_white_sat_lim   <= RST_WHITE_SATURATION_LIMIT;
            r_white_val_floor <= RST_WHITE_VALUE_FLOOR;
            r_hue_tol         <= RST_HUE_TOLERANCE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_LINE_HUE:               r_line_hue        <= i_cfg_wdata;
                CFG_LINE_SATURATION:        r_line_sat        <= i_cfg_wdata;
                CFG_LINE_VALUE:             r_line_val        <= i_cfg_wdata;
                CFG_BLACK_VALUE_LIMIT:      r_black_lim       <= i_cfg_wdata;
                CFG_WHITE_SATURATION_LIMIT: r_white_sat_lim   <= i_cfg_wdata;
                CFG_WHITE_VALUE_FLOOR:      r_white_val_floor <= i_cfg_wdata;
                CFG_HUE_TOLERANCE:          r_hue_tol         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        pix_white  = (i_pixel_saturation < r_white_sat_lim) &&
                     (i_pixel_value > r_white_val_floor);
        line_white = (r_line_sat < r_white_sat_lim) && (r_line_val > r_white_val_floor);
        pix_black  = i_pixel_value < r_black_lim;
        line_black = r_line_val < r_black_lim;

        // out-of-range hues can make the wrapped distance negative; that matches
        hue_diff = $signed({2'b00, i_pixel_hue}) - $signed({2'b00, r_line_hue});
        hue_abs  = (hue_diff < 0) ? -hue_diff : hue_diff;
        hue_alt  = HUE_WRAP - hue_abs;
        hue_dist = (hue_alt < hue_abs) ? hue_alt : hue_abs;
        hue_match = hue_dist < $signed({2'b00, r_hue_tol});

        if (pix_white && line_white) begin
            color_match = 1'b1;
        end else if (pix_black && line_black) begin
            color_match = 1'b1;
        end else if (pix_white || line_white || pix_black || line_black) begin
            color_match = 1'b0;
        end else begin
            color_match = hue_match;
        end

        o_item.wall      = i_is_dark && !color_match;
        o_item.row_end   = i_row_end;
        o_item.frame_end = i_frame_end;
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbwa_queue.sv
// Small FIFO between the classifier and the gap engine.
`default_nettype none

module gbwa_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    input  wire gbwa_pkg::t_item  i_data,
    output logic                  o_full,
    input  wire                   i_pop,
    output gbwa_pkg::t_item       o_data,
    output logic                  o_empty
);
    import gbwa_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbwa_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module gbwa_divider (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire [gbwa_pkg::SUM_W-1:0]   i_dividend,
    input  wire [gbwa_pkg::COUNT_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [gbwa_pkg::SUM_W-1:0]  o_quotient
);
    import gbwa_pkg::*;

    localparam int unsigned STEP_W = $clog2(SUM_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic                r_busy, r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_rem, r_quo;
    logic [COUNT_W-1:0]  r_div;
    logic [SUM_W-1:0]    trial;
    logic                fits;

    assign trial      = {r_rem[SUM_W-2:0], r_quo[SUM_W-1]};
    assign fits       = trial >= {1'b0, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbwa_engine.sv
// Back end: gap tracking per row, frame statistics and result register.
`default_nettype none

module gbwa_engine (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire gbwa_pkg::t_item  i_item,
    input  wire                   i_item_empty,
    output logic                  o_item_pop,
    output gbwa_pkg::t_result     o_result,
    output logic                  o_result_valid,
    input  wire                   i_result_pop
);
    import gbwa_pkg::*;

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_DIV = 3'b010,
        ST_OUT = 3'b100
    } t_state;

    t_state              r_state;
    logic                r_wall_seen;
    logic [RUN_W-1:0]    r_run;
    logic [COUNT_W-1:0]  r_found;
    logic [SUM_W-1:0]    r_total;
    logic [COUNT_W-1:0]  r_res_count;
    logic [SUM_W-1:0]    r_res_sum;
    t_result             r_out;
    logic                r_out_valid;
    logic                r_div_start;

    logic                closes_gap;
    logic [COUNT_W-1:0]  n_found;
    logic [SUM_W-1:0]    n_total;
    logic [SUM_W:0]      sum_wide;
    logic                div_done;
    logic [SUM_W-1:0]    quotient;
    logic                load_out, res_zero;

    gbwa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_res_sum),
        .i_divisor  (r_res_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        o_item_pop = (r_state == ST_RUN) && !i_item_empty;
        closes_gap = i_item.wall && r_wall_seen && (r_run != '0);
        sum_wide   = {1'b0, r_total} + {{(SUM_W + 1 - RUN_W){1'b0}}, r_run};
        n_found    = r_found;
        n_total    = r_total;
        if (closes_gap) begin
            n_found = (r_found == COUNT_MAX) ? r_found : r_found + 1'b1;
            n_total = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
        end
        load_out = (r_state == ST_OUT) && (!r_out_valid || i_result_pop);
        res_zero = (r_res_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_wall_seen <= 1'b0;
            r_run       <= '0;
            r_found     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                ST_RUN: begin
                    if (o_item_pop) begin
                        if (i_item.wall) begin
                            r_wall_seen <= 1'b1;
                            r_run       <= '0;
                        end else if (r_wall_seen && r_run != RUN_MAX) begin
                            r_run <= r_run + 1'b1;
                        end
                        if (i_item.row_end || i_item.frame_end) begin
                            r_wall_seen <= 1'b0;
                            r_run       <= '0;
                        end
                        if (i_item.frame_end) begin
                            r_found     <= '0;
                            r_total     <= '0;
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV;
                        end else begin
                            r_found <= n_found;
                            r_total <= n_total;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        r_state <= ST_RUN;
                    end
                end
                default: r_state <= ST_RUN;
            endcase

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_result_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // frame totals are latched for the divider and the result
    always_ff @(posedge i_clk) begin
        if (o_item_pop && i_item.frame_end) begin
            r_res_count <= n_found;
            r_res_sum   <= n_total;
        end
        if (load_out) begin
            r_out.gap_count      <= r_res_count;
            r_out.gap_length_sum <= r_res_sum;
            r_out.no_gaps        <= res_zero;
            if (res_zero) begin
                r_out.average_gap <= '0;
            end else if (quotient > {{(SUM_W - AVG_W){1'b0}}, AVG_MAX}) begin
                r_out.average_gap <= AVG_MAX;
            end else begin
                r_out.average_gap <= quotient[AVG_W-1:0];
            end
        end
    end

    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

endmodule

`default_nettype wire

>>> hw/rtl/bounded_gap_width_average_core.sv
// Top level of the bounded gap width average block.
// Throughput: one pixel per cycle; a frame end stops the gap engine for the
//   divide start, the divide and the result load, longer if a result waits.
// Result path: a frame-end pixel passes through the queue, the divide and the
//   result register before its result is shown.
// Reset: synchronous, active low; clears queue, gap state and counters, and loads the config defaults.
`default_nettype none

module bounded_gap_width_average_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration write port
    input  wire                          i_cfg_we,
    input  wire [gbwa_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire [gbwa_pkg::COLOR_W-1:0]  i_cfg_wdata,
    // pixel input, queue-style
    input  wire                          push,
    output logic                         full,
    input  wire [gbwa_pkg::COLOR_W-1:0]  i_pixel_hue,
    input  wire [gbwa_pkg::COLOR_W-1:0]  i_pixel_saturation,
    input  wire [gbwa_pkg::COLOR_W-1:0]  i_pixel_value,
    input  wire                          i_is_dark,
    input  wire                          i_row_end,
    input  wire                          i_frame_end,
    // frame result, queue-style
    output logic                         empty,
    input  wire                          pop,
    output logic [gbwa_pkg::AVG_W-1:0]   o_average_gap,
    output logic [gbwa_pkg::COUNT_W-1:0] o_gap_count,
    output logic [gbwa_pkg::SUM_W-1:0]   o_gap_length_sum,
    output logic                         o_no_gaps
);
    import gbwa_pkg::*;

    t_item   cls_item, q_item;
    logic    q_empty, q_pop;
    t_result result;
    logic    result_valid;

    // Front: classify each pixel as wall or free against the line color.
    gbwa_classify u_classify (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_pixel_hue        (i_pixel_hue),
        .i_pixel_saturation (i_pixel_saturation),
        .i_pixel_value      (i_pixel_value),
        .i_is_dark          (i_is_dark),
        .i_row_end          (i_row_end),
        .i_frame_end        (i_frame_end),
        .o_item             (cls_item)
    );

    // Decoupling queue: input transactions land here; full backs up the source
    // while the engine is busy dividing at frame end.
    gbwa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    // Back: run tracking, frame sums, average and the result register.
    gbwa_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (q_item),
        .i_item_empty   (q_empty),
        .o_item_pop     (q_pop),
        .o_result       (result),
        .o_result_valid (result_valid),
        .i_result_pop   (pop)
    );

    assign empty            = !result_valid;
    assign o_average_gap    = result.average_gap;
    assign o_gap_count      = result.gap_count;
    assign o_gap_length_sum = result.gap_length_sum;
    assign o_no_gaps        = result.no_gaps;

endmodule

`default_nettype wire

>>> dv/gbwa_frame_checker.sv
// Frame result checker for the bounded gap width average block.
module gbwa_frame_checker (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [gbwa_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_cfg_wdata,
    input  wire                         i_push,
    input  wire                         i_full,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_pixel_hue,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_pixel_saturation,
    input  wire [gbwa_pkg::COLOR_W-1:0] i_pixel_value,
    input  wire                         i_is_dark,
    input  wire                         i_row_end,
    input  wire                         i_frame_end,
    input  wire                         i_empty,
    input  wire                         i_pop,
    input  wire [gbwa_pkg::AVG_W-1:0]   i_average_gap,
    input  wire [gbwa_pkg::COUNT_W-1:0] i_gap_count,
    input  wire [gbwa_pkg::SUM_W-1:0]   i_gap_length_sum,
    input  wire                         i_no_gaps,
    output int                          o_fail_count,
    output int                          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import gbwa_pkg::*;

    // shadow of the configuration registers
    logic [COLOR_W-1:0] line_hue, line_sat, line_val;
    logic [COLOR_W-1:0] black_limit, white_sat_limit, white_floor, hue_tol;

    // gap scan state
    logic               wall_seen;
    logic [RUN_W-1:0]   run_len;
    logic [COUNT_W-1:0] gaps_found;
    logic [SUM_W-1:0]   gaps_total;

    t_result frame_results_q[$];
    int      fail_n = 0;

    always @(posedge i_clk) begin
        logic        pix_white, line_white, pix_black, line_black, is_wall;
        int          hue_dist, wrap_dist;
        int unsigned avg;
        logic [SUM_W:0] sum_next;
        t_result     got, want;

        if (!i_rst_n) begin
            line_hue        = '0;
            line_sat        = '0;
            line_val        = '0;
            black_limit     = RST_BLACK_VALUE_LIMIT;
            white_sat_limit = RST_WHITE_SATURATION_LIMIT;
            white_floor     = RST_WHITE_VALUE_FLOOR;
            hue_tol         = RST_HUE_TOLERANCE;
            wall_seen       = 1'b0;
            run_len         = '0;
            gaps_found      = '0;
            gaps_total      = '0;
            frame_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    CFG_LINE_HUE:               line_hue        = i_cfg_wdata;
                    CFG_LINE_SATURATION:        line_sat        = i_cfg_wdata;
                    CFG_LINE_VALUE:             line_val        = i_cfg_wdata;
                    CFG_BLACK_VALUE_LIMIT:      black_limit     = i_cfg_wdata;
                    CFG_WHITE_SATURATION_LIMIT: white_sat_limit = i_cfg_wdata;
                    CFG_WHITE_VALUE_FLOOR:      white_floor     = i_cfg_wdata;
                    CFG_HUE_TOLERANCE:          hue_tol         = i_cfg_wdata;
                    default: ;
                endcase
            end

            // result side first: a frame accepted this edge cannot already be out
            if (i_pop && !i_empty) begin
                got = '{average_gap: i_average_gap, gap_count: i_gap_count,
                        gap_length_sum: i_gap_length_sum, no_gaps: i_no_gaps};
                if (frame_results_q.size() == 0) begin
                    fail_n++;
                    $display("%0t: unexpected result avg=%0d count=%0d sum=%0d none=%0b",
                             $time, got.average_gap, got.gap_count, got.gap_length_sum,
                             got.no_gaps);
                end else begin
                    want = frame_results_q.pop_front();
                    if (got.average_gap !== want.average_gap) begin
                        fail_n++;
                        $display("%0t: average_gap expected %0d actual %0d",
                                 $time, want.average_gap, got.average_gap);
                    end
                    if (got.gap_count !== want.gap_count) begin
                        fail_n++;
                        $display("%0t: gap_count expected %0d actual %0d",
                                 $time, want.gap_count, got.gap_count);
                    end
                    if (got.gap_length_sum !== want.gap_length_sum) begin
                        fail_n++;
                        $display("%0t: gap_length_sum expected %0d actual %0d",
                                 $time, want.gap_length_sum, got.gap_length_sum);
                    end
                    if (got.no_gaps !== want.no_gaps) begin
                        fail_n++;
                        $display("%0t: no_gaps expected %0b actual %0b",
                                 $time, want.no_gaps, got.no_gaps);
                    end
                end
            end

            if (i_push && !i_full) begin
                pix_white  = (i_pixel_saturation < white_sat_limit) &&
                             (i_pixel_value > white_floor);
                line_white = (line_sat < white_sat_limit) && (line_val > white_floor);
                pix_black  = i_pixel_value < black_limit;
                line_black = line_val < black_limit;
                if (pix_white && line_white)
                    is_wall = 1'b0;
                else if (pix_black && line_black)
                    is_wall = 1'b0;
                else if (pix_white || line_white || pix_black || line_black)
                    is_wall = i_is_dark;
                else begin
                    // circular distance; hues past the wrap can go negative and match
                    hue_dist = int'(i_pixel_hue) - int'(line_hue);
                    if (hue_dist < 0)
                        hue_dist = -hue_dist;
                    wrap_dist = int'(HUE_WRAP) - hue_dist;
                    if (wrap_dist < hue_dist)
                        hue_dist = wrap_dist;
                    is_wall = i_is_dark && !(hue_dist < int'(hue_tol));
                end

                if (is_wall) begin
                    if (wall_seen && run_len != 0) begin
                        if (gaps_found != COUNT_MAX)
                            gaps_found++;
                        sum_next = {1'b0, gaps_total} + run_len;
                        gaps_total = (sum_next > SUM_MAX) ? SUM_MAX : sum_next[SUM_W-1:0];
                    end
                    wall_seen = 1'b1;
                    run_len   = '0;
                end else if (wall_seen && run_len != RUN_MAX) begin
                    run_len++;
                end

                if (i_row_end || i_frame_end) begin
                    wall_seen = 1'b0;
                    run_len   = '0;
                end

                if (i_frame_end) begin
                    avg = 0;
                    if (gaps_found != 0) begin
                        avg = gaps_total / gaps_found;
                        if (avg > AVG_MAX)
                            avg = AVG_MAX;
                    end
                    want.average_gap    = AVG_W'(avg);
                    want.gap_count      = gaps_found;
                    want.gap_length_sum = gaps_total;
                    want.no_gaps        = (gaps_found == 0);
                    frame_results_q.insert(frame_results_q.size(), want);
                    gaps_found = '0;
                    gaps_total = '0;
                end
            end
        end
        o_outstanding <= frame_results_q.size();
        o_fail_count  <= fail_n;
    end

endmodule

>>> dv/tb_top.sv
// Testbench top for the bounded gap width average block: stimulus, pacing and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbwa_pkg::*;

    // cycles to let a frame-end transaction finish its divide and handoff
    localparam int SETTLE_CYCLES = 40;
    // bound on waiting for outstanding frame results in one drain
    localparam int DRAIN_LIMIT   = 3000;
    // the receiver goes quiet this long once, after this many results
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 1;
    localparam int PHASE_PIXELS  = 220;
    localparam int NUM_PHASES    = 8;
    localparam int LONG_RUN      = 60;

    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_cfg_we           = 1'b0;
    logic [CFG_AW-1:0]  i_cfg_addr         = '0;
    logic [COLOR_W-1:0] i_cfg_wdata        = '0;
    logic               push               = 1'b0;
    logic [COLOR_W-1:0] i_pixel_hue        = '0;
    logic [COLOR_W-1:0] i_pixel_saturation = '0;
    logic [COLOR_W-1:0] i_pixel_value      = '0;
    logic               i_is_dark          = 1'b0;
    logic               i_row_end          = 1'b0;
    logic               i_frame_end        = 1'b0;
    logic               pop                = 1'b0;

    wire                full;
    wire                empty;
    wire [AVG_W-1:0]    o_average_gap;
    wire [COUNT_W-1:0]  o_gap_count;
    wire [SUM_W-1:0]    o_gap_length_sum;
    wire                o_no_gaps;

    int fail_count;
    int outstanding;

    // current register values, kept so random pixels can aim at the line color
    logic [COLOR_W-1:0] cur_cfg [7];
    int                 send_calm = 0;

    always #6 i_clk = ~i_clk;

    bounded_gap_width_average_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .push              (push),
        .full              (full),
        .i_pixel_hue       (i_pixel_hue),
        .i_pixel_saturation(i_pixel_saturation),
        .i_pixel_value     (i_pixel_value),
        .i_is_dark         (i_is_dark),
        .i_row_end         (i_row_end),
        .i_frame_end       (i_frame_end),
        .empty             (empty),
        .pop               (pop),
        .o_average_gap     (o_average_gap),
        .o_gap_count       (o_gap_count),
        .o_gap_length_sum  (o_gap_length_sum),
        .o_no_gaps         (o_no_gaps)
    );

    gbwa_frame_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_push            (push),
        .i_full            (full),
        .i_pixel_hue       (i_pixel_hue),
        .i_pixel_saturation(i_pixel_saturation),
        .i_pixel_value     (i_pixel_value),
        .i_is_dark         (i_is_dark),
        .i_row_end         (i_row_end),
        .i_frame_end       (i_frame_end),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_average_gap     (o_average_gap),
        .i_gap_count       (o_gap_count),
        .i_gap_length_sum  (o_gap_length_sum),
        .i_no_gaps         (o_no_gaps),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding)
    );

    // One pixel transaction. The idle draw comes first; push is only lowered
    // when there is an actual gap, so back-to-back pixels keep it high.
    task automatic send_pixel(input logic [COLOR_W-1:0] hue, sat, val,
                              input logic dark, row_last, frame_last);
        int idle;
        if (send_calm > 0) begin
            send_calm--;
            idle = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            send_calm = $urandom_range(10, 40);     // a stretch at full rate
            idle = 0;
        end else begin
            idle = $urandom_range(0, 4);
        end
        if (idle > 0) begin
            push <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_pixel_hue        <= hue;
        i_pixel_saturation <= sat;
        i_pixel_value      <= val;
        i_is_dark          <= dark;
        i_row_end          <= row_last;
        i_frame_end        <= frame_last;
        push               <= 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering pixels, wait for every predicted frame result, then give
    // the divider time to finish anything still in flight.
    task automatic drain_pipeline();
        int waited;
        push <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all seven registers from cur_cfg, one per cycle, we held high.
    task automatic write_config();
        t_cfg_reg idx;
        idx = idx.first();
        do begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_wdata <= cur_cfg[idx];
            @(posedge i_clk);
            idx = idx.next();
        end while (idx != idx.first());
        i_cfg_we <= 1'b0;
    endtask

    // One random frame: 1..5 rows, mostly short, a few wide. Pixel colors mix
    // fully random values with ones aimed at the line color, near the hue
    // tolerance edge, at the black and white limits and past the hue wrap.
    // Some frames end mid-row (frame end without row end).
    task automatic random_frame(inout int items);
        int                 rows, width, kind, off;
        logic               cut, row_last, frame_last;
        logic [COLOR_W-1:0] hue, sat, val;
        rows = $urandom_range(1, 5);
        cut  = ($urandom_range(0, 5) == 0);
        for (int r = 0; r < rows; r++) begin
            width = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (int c = 0; c < width; c++) begin
                frame_last = (r == rows - 1) && (c == width - 1);
                row_last   = (c == width - 1) && !(frame_last && cut);
                kind = $urandom_range(0, 9);
                hue  = COLOR_W'($urandom_range(0, 255));
                sat  = COLOR_W'($urandom_range(0, 255));
                val  = COLOR_W'($urandom_range(0, 255));
                case (kind)
                    4, 5, 6: begin
                        off = $urandom_range(0, cur_cfg[CFG_HUE_TOLERANCE] + 2);
                        hue = COLOR_W'($urandom_range(0, 1) ? cur_cfg[CFG_LINE_HUE] + off
                                                            : cur_cfg[CFG_LINE_HUE] - off);
                        sat = cur_cfg[CFG_LINE_SATURATION];
                        val = cur_cfg[CFG_LINE_VALUE];
                    end
                    7: val = COLOR_W'($urandom_range(0, cur_cfg[CFG_BLACK_VALUE_LIMIT]));
                    8: begin
                        sat = COLOR_W'($urandom_range(0, cur_cfg[CFG_WHITE_SATURATION_LIMIT]));
                        val = COLOR_W'($urandom_range(cur_cfg[CFG_WHITE_VALUE_FLOOR], 255));
                    end
                    9: hue = COLOR_W'($urandom_range(170, 255));
                    default: ;
                endcase
                send_pixel(hue, sat, val, $urandom_range(0, 2) != 0, row_last, frame_last);
                items++;
            end
        end
    endtask

    // Result side: random pops, stretches at full rate, and one long hold-off
    // so the result register stays full and the block backs up onto push.
    initial begin
        int idle, taken, calm;
        taken = 0;
        calm  = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken == HOLD_AFTER) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (calm > 0) begin
                    calm--;
                    idle = 0;
                end else if ($urandom_range(0, 9) == 0) begin
                    calm = $urandom_range(5, 20);
                    idle = 0;
                end else begin
                    idle = $urandom_range(0, 4);
                end
                if (idle > 0) begin
                    pop <= 1'b0;
                    repeat (idle) @(posedge i_clk);
                end
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            taken++;
        end
    end

    initial begin
        int phase_pixels;

        cur_cfg[CFG_LINE_HUE]               = '0;
        cur_cfg[CFG_LINE_SATURATION]        = '0;
        cur_cfg[CFG_LINE_VALUE]             = '0;
        cur_cfg[CFG_BLACK_VALUE_LIMIT]      = RST_BLACK_VALUE_LIMIT;
        cur_cfg[CFG_WHITE_SATURATION_LIMIT] = RST_WHITE_SATURATION_LIMIT;
        cur_cfg[CFG_WHITE_VALUE_FLOOR]      = RST_WHITE_VALUE_FLOOR;
        cur_cfg[CFG_HUE_TOLERANCE]          = RST_HUE_TOLERANCE;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at reset config: line color is black, so a dark
        // saturated bright pixel (hue 90, s 255, v 255) is a wall and any
        // undark pixel or dark black pixel is free.

        // empty frame: lone black dark pixel, frame end without row end
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b1);

        // row 1: free run before first wall is ignored, gap of 2, adjacent
        // walls give nothing, trailing run dropped at row end
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd90,  8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b1, 1'b0, 1'b0);
        send_pixel(8'd179, 8'd128, 8'd94,  1'b1, 1'b0, 1'b0);   // just black
        send_pixel(8'd0,   8'd19,  8'd241, 1'b1, 1'b0, 1'b0);   // white vs black line
        send_pixel(8'd180, 8'd20,  8'd95,  1'b1, 1'b0, 1'b0);   // just not white/black
        send_pixel(8'd1,   8'd1,   8'd1,   1'b0, 1'b0, 1'b0);
        send_pixel(8'd127, 8'd127, 8'd127, 1'b0, 1'b1, 1'b0);
        // row 2: leading free pixel, then gap of 1 closed on the row-end pixel
        send_pixel(8'd64,  8'd64,  8'd200, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd90,  8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
        send_pixel(8'd128, 8'd127, 8'd128, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd90,  8'd255, 8'd255, 1'b1, 1'b1, 1'b0);
        // row 3: gap of 3 closed by the frame-end pixel, no row end on it
        send_pixel(8'd90,  8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
        send_pixel(8'd10,  8'd200, 8'd100, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd20,  8'd200, 8'd100, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd30,  8'd200, 8'd100, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd90,  8'd255, 8'd255, 1'b1, 1'b0, 1'b1);

        // a wall does not bound a run across a row boundary: no gaps
        send_pixel(8'd90,  8'd255, 8'd255, 1'b1, 1'b1, 1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 1'b0);
        send_pixel(8'd90,  8'd255, 8'd255, 1'b1, 1'b1, 1'b1);

        // one wide row holding a single long gap
        send_pixel(8'd90, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
        for (int i = 0; i < LONG_RUN; i++)
            send_pixel(COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
                       COLOR_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
        send_pixel(8'd90, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
        drain_pipeline();

        // Random phases, each under its own register setting, written while idle.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: cur_cfg = '{8'd0,   8'd0,   8'd0,   8'd95,  8'd20,  8'd240, 8'd40};
                1: cur_cfg = '{8'd90,  8'd200, 8'd200, 8'd95,  8'd20,  8'd240, 8'd40};
                // high extremes: nearly everything black, wide white, full tolerance
                2: cur_cfg = '{8'd179, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd180};
                // low extremes: no black, no white, zero tolerance
                3: cur_cfg = '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0};
                4: cur_cfg = '{8'd45,  8'd128, 8'd128, 8'd60,  8'd40,  8'd200, 8'd90};
                // white line color
                5: cur_cfg = '{8'd170, 8'd10,  8'd250, 8'd30,  8'd25,  8'd235, 8'd20};
                default: begin
                    cur_cfg[CFG_LINE_HUE]               = COLOR_W'($urandom_range(0, 179));
                    cur_cfg[CFG_LINE_SATURATION]        = COLOR_W'($urandom_range(0, 255));
                    cur_cfg[CFG_LINE_VALUE]             = COLOR_W'($urandom_range(0, 255));
                    cur_cfg[CFG_BLACK_VALUE_LIMIT]      = COLOR_W'($urandom_range(0, 255));
                    cur_cfg[CFG_WHITE_SATURATION_LIMIT] = COLOR_W'($urandom_range(0, 255));
                    cur_cfg[CFG_WHITE_VALUE_FLOOR]      = COLOR_W'($urandom_range(0, 255));
                    cur_cfg[CFG_HUE_TOLERANCE]          = COLOR_W'($urandom_range(0, 180));
                end
            endcase
            write_config();
            phase_pixels = 0;
            while (phase_pixels < PHASE_PIXELS)
                random_frame(phase_pixels);
            drain_pipeline();
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            if (outstanding != 0)
                $display("%0t: %0d expected frame results never arrived", $time, outstanding);
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
